// ===== rtl/core/fbme_pkg.sv =====
// Package for the fuzz buffer mutation engine: sizes, command codes,
// sequencer states and the interesting-value tables. No dependencies.
package fbme_pkg;

    localparam int BUF_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(BUF_BYTES);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int MAX_BLK     = 16;
    localparam int ARITH_LIMIT = 35;

    typedef enum logic [3:0] {
        CMD_APPEND = 4'd0,
        CMD_READ   = 4'd1,
        CMD_CLEAR  = 4'd2,
        CMD_FLIP   = 4'd3,
        CMD_ARITH  = 4'd4,
        CMD_INTR   = 4'd5,
        CMD_DELETE = 4'd6,
        CMD_DUP    = 4'd7,
        CMD_STATUS = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RD_TAKE,
        S_MODIFY,
        S_WR_BACK,
        S_CP_ISSUE,
        S_CP_WAIT,
        S_CP_WRITE,
        S_BLK_WRITE,
        S_OUT
    } t_state;

    // Copy phases of a block move.
    typedef enum logic [1:0] {
        PH_SAVE,
        PH_SHIFT,
        PH_PLACE
    } t_phase;

    // RAM request from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [7:0] tab8(input logic [4:0] i);
        case (i)
            5'd0: tab8 = 8'h80;  5'd1: tab8 = 8'hFF;  5'd2: tab8 = 8'h00;
            5'd3: tab8 = 8'h01;  5'd4: tab8 = 8'h10;  5'd5: tab8 = 8'h20;
            5'd6: tab8 = 8'h40;  5'd7: tab8 = 8'h64;  5'd8: tab8 = 8'h7F;
            default: tab8 = 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] tab16(input logic [4:0] i);
        case (i)
            5'd0: tab16 = 16'h8000;   5'd1: tab16 = 16'hFF80;
            5'd2: tab16 = 16'hFFFF;   5'd3: tab16 = 16'h0000;
            5'd4: tab16 = 16'h0001;   5'd5: tab16 = 16'h0010;
            5'd6: tab16 = 16'h0020;   5'd7: tab16 = 16'h0064;
            5'd8: tab16 = 16'h0080;   5'd9: tab16 = 16'h00FF;
            5'd10: tab16 = 16'h0100;  5'd11: tab16 = 16'h0200;
            5'd12: tab16 = 16'h03E8;  5'd13: tab16 = 16'h0400;
            5'd14: tab16 = 16'h1000;  5'd15: tab16 = 16'h7FFF;
            default: tab16 = 16'h0000;
        endcase
    endfunction

    function automatic logic [31:0] tab32(input logic [4:0] i);
        case (i)
            5'd0: tab32 = 32'h80000000;   5'd1: tab32 = 32'hFA0000FA;
            5'd2: tab32 = 32'hFFFF8000;   5'd3: tab32 = 32'hFFFFFF80;
            5'd4: tab32 = 32'hFFFFFFFF;   5'd5: tab32 = 32'h00000000;
            5'd6: tab32 = 32'h00000001;   5'd7: tab32 = 32'h00000010;
            5'd8: tab32 = 32'h00000020;   5'd9: tab32 = 32'h00000064;
            5'd10: tab32 = 32'h00000080;  5'd11: tab32 = 32'h000000FF;
            5'd12: tab32 = 32'h00000100;  5'd13: tab32 = 32'h00000200;
            5'd14: tab32 = 32'h000003E8;  5'd15: tab32 = 32'h00000400;
            5'd16: tab32 = 32'h00001000;  5'd17: tab32 = 32'h00007FFF;
            5'd18: tab32 = 32'h0000FFFF;  5'd19: tab32 = 32'h05FFFF06;
            5'd20: tab32 = 32'h7FFFFFFF;
            default: tab32 = 32'h00000000;
        endcase
    endfunction

endpackage

// ===== rtl/core/fbme_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fbme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/fbme_word_unit.sv =====
// Word edit unit: bit flip, add/subtract with byte swaps, interesting-value
// write on a gathered little-endian word. Uses fbme_pkg.
module fbme_word_unit (
    input  logic [3:0]  i_cmd,
    input  logic [1:0]  i_size_select,
    input  logic [2:0]  i_bit_offset,
    input  logic [5:0]  i_amount,
    input  logic        i_subtract,
    input  logic        i_swap_before,
    input  logic        i_swap_after,
    input  logic [4:0]  i_table_index,
    input  logic [31:0] i_word,
    output logic [31:0] o_word
);
    import fbme_pkg::*;

    logic [31:0] w_sw;
    logic [31:0] w_sum;
    logic [31:0] w_msk;
    logic [31:0] w_tab;
    logic [31:0] w_flip;
    logic [7:0]  w_flip_bits;

    function automatic logic [31:0] swap(input logic [31:0] v, input logic [1:0] sel);
        case (sel)
            2'd1: swap = {16'h0, v[7:0], v[15:8]};
            2'd2: swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
            default: swap = v;
        endcase
    endfunction

    always_comb begin
        // Bit flip: bits MSB-first from the offset, spanning at most two bytes
        case (i_size_select)
            2'd0: w_flip_bits = 8'h80;
            2'd1: w_flip_bits = 8'hC0;
            default: w_flip_bits = 8'hF0;
        endcase
        w_flip = i_word ^ {16'h0,
                           8'(({w_flip_bits, 8'h00} >> i_bit_offset)),
                           8'(({w_flip_bits, 8'h00} >> i_bit_offset) >> 8)};
        // Arithmetic
        case (i_size_select)
            2'd0: w_msk = 32'h000000FF;
            2'd1: w_msk = 32'h0000FFFF;
            default: w_msk = 32'hFFFFFFFF;
        endcase
        w_sw  = i_swap_before ? swap(i_word, i_size_select) : i_word;
        w_sum = (i_subtract ? w_sw - 32'(i_amount) : w_sw + 32'(i_amount)) & w_msk;
        // Table value
        case (i_size_select)
            2'd0: w_tab = {24'h0, tab8(i_table_index)};
            2'd1: w_tab = {16'h0, tab16(i_table_index)};
            default: w_tab = tab32(i_table_index);
        endcase
        case (i_cmd)
            CMD_FLIP:  o_word = w_flip;
            CMD_ARITH: o_word = i_swap_after ? swap(w_sum, i_size_select) : w_sum;
            default:   o_word = i_swap_before ? swap(w_tab, i_size_select) : w_tab;
        endcase
    end
endmodule

// ===== rtl/core/fbme_seq.sv =====
// Sequencer: range checks, byte gather/scatter for word edits, and the
// block move, one byte at a time. Uses fbme_pkg, fbme_word_unit.
module fbme_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [3:0]                 i_cmd,
    input  logic [14:0]                i_position,
    input  logic [1:0]                 i_size_select,
    input  logic [5:0]                 i_amount,
    input  logic                       i_subtract,
    input  logic                       i_swap_before,
    input  logic                       i_swap_after,
    input  logic [4:0]                 i_table_index,
    input  logic [7:0]                 i_data_byte,
    input  logic [4:0]                 i_block_length,
    input  logic [12:0]                i_dest_position,
    output fbme_pkg::t_mem_req         o_mem,
    input  logic [7:0]                 i_rdata,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_read_data,
    output logic [12:0]                o_buffer_length,
    output logic [1:0]                 o_status
);
    import fbme_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [3:0]  r_cmd;
    logic [14:0] r_pos;
    logic [1:0]  r_sel;
    logic [5:0]  r_amount;
    logic        r_sub, r_swb, r_swa;
    logic [4:0]  r_tix;
    logic [7:0]  r_data;
    logic [4:0]  r_blen;
    logic [12:0] r_dest;
    logic [LEN_W-1:0] r_len, n_len;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0] r_ptr, n_ptr;
    logic [LEN_W-1:0] r_left, n_left;
    logic [7:0]  r_tmp [MAX_BLK];
    logic [7:0]  r_rd, n_rd;
    logic [1:0]  r_st, n_st;
    logic        w_tmp_we;
    logic [3:0]  w_tmp_idx;
    logic [31:0] w_new;
    logic [2:0]  w_nbytes;
    logic [3:0]  w_n;
    logic [ADDR_W-1:0] w_base;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_cp_addr;
    logic [LEN_W+2:0]  w_bits;
    logic [15:0] w_pend;

    fbme_word_unit u_word (
        .i_cmd(r_cmd), .i_size_select(r_sel), .i_bit_offset(r_pos[2:0]),
        .i_amount(r_amount), .i_subtract(r_sub), .i_swap_before(r_swb),
        .i_swap_after(r_swa), .i_table_index(r_tix), .i_word(r_word), .o_word(w_new)
    );

    always_comb begin
        case (r_sel)
            2'd0: w_n = 4'd1;
            2'd1: w_n = 4'd2;
            default: w_n = 4'd4;
        endcase
        // A flip touches one byte, or two when it crosses a byte edge
        w_nbytes = (r_cmd == CMD_FLIP) ?
            ((4'(r_pos[2:0]) + w_n > 4'd8) ? 3'd2 : 3'd1) : w_n[2:0];
        w_base = (r_cmd == CMD_FLIP) ? ADDR_W'(r_pos >> 3) : ADDR_W'(r_pos);
        w_bits = {r_len, 3'b000};
        w_pend = 16'(r_pos) + 16'(r_blen);
        // Read addresses, held through the RAM wait cycle
        w_rd_addr = (r_cmd == CMD_READ) ? ADDR_W'(r_pos) : w_base + ADDR_W'(r_cnt);
        if (r_phase == PH_SAVE) begin
            w_cp_addr = ADDR_W'(r_pos) + ADDR_W'(r_ptr);
        end else if (r_cmd == CMD_DELETE) begin
            w_cp_addr = ADDR_W'(r_ptr) + ADDR_W'(r_blen);
        end else begin
            w_cp_addr = ADDR_W'(r_ptr);
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_phase <= n_phase;
        r_word  <= n_word;
        r_cnt   <= n_cnt;
        r_ptr   <= n_ptr;
        r_left  <= n_left;
        r_rd    <= n_rd;
        r_st    <= n_st;
        if (w_tmp_we) begin
            r_tmp[w_tmp_idx] <= i_rdata;
        end
        if (i_valid && r_state == S_IDLE) begin
            r_cmd <= i_cmd; r_pos <= i_position; r_sel <= i_size_select;
            r_amount <= i_amount; r_sub <= i_subtract; r_swb <= i_swap_before;
            r_swa <= i_swap_after; r_tix <= i_table_index; r_data <= i_data_byte;
            r_blen <= i_block_length; r_dest <= i_dest_position;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state; n_phase = r_phase; n_len = r_len; n_word = r_word;
        n_cnt = r_cnt; n_ptr = r_ptr; n_left = r_left; n_rd = r_rd; n_st = r_st;
        o_mem = '0;
        w_tmp_we = 1'b0;
        w_tmp_idx = 4'(r_ptr);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rd = '0; n_st = ST_DONE; n_state = S_OUT; n_cnt = '0; n_word = '0;
                case (r_cmd)
                    CMD_APPEND: begin
                        if (r_len >= LEN_W'(BUF_BYTES)) begin
                            n_st = ST_FULL;
                        end else begin
                            o_mem.we = 1'b1; o_mem.waddr = ADDR_W'(r_len);
                            o_mem.wdata = r_data; n_len = r_len + 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (16'(r_pos) >= 16'(r_len)) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_cnt = 3'd7; n_state = S_RD_ISSUE;
                        end
                    end
                    CMD_CLEAR: n_len = '0;
                    CMD_FLIP, CMD_ARITH, CMD_INTR: begin
                        if (r_sel == 2'd3
                            || (r_cmd == CMD_FLIP && 20'(r_pos) + 20'(w_n) > 20'(w_bits))
                            || (r_cmd != CMD_FLIP && 16'(r_pos) + 16'(w_n) > 16'(r_len))
                            || (r_cmd == CMD_ARITH && (r_amount < 6'd1
                                || r_amount > 6'(ARITH_LIMIT)))
                            || (r_cmd == CMD_INTR && ((r_sel == 2'd0 && r_tix >= 5'd9)
                                || (r_sel == 2'd1 && r_tix >= 5'd16)
                                || (r_sel == 2'd2 && r_tix >= 5'd21)))) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_state = S_RD_ISSUE;
                        end
                    end
                    CMD_DELETE, CMD_DUP: begin
                        if (r_blen < 5'd1 || r_blen > 5'(MAX_BLK) || r_len < LEN_W'(2)
                            || 16'(r_blen) > 16'(r_len) - 16'd1
                            || w_pend > 16'(r_len)) begin
                            n_st = ST_RANGE;
                        end else if (r_cmd == CMD_DELETE) begin
                            // Pull bytes down from pos+blen to the end
                            n_phase = PH_SHIFT; n_ptr = LEN_W'(r_pos);
                            n_left = r_len - LEN_W'(w_pend);
                            n_state = S_CP_ISSUE;
                        end else if (r_dest > 13'(r_len)) begin
                            n_st = ST_RANGE;
                        end else if (16'(r_len) + 16'(r_blen) > 16'(BUF_BYTES)) begin
                            n_st = ST_FULL;
                        end else begin
                            n_phase = PH_SAVE; n_ptr = '0;
                            n_left = LEN_W'(r_blen); n_state = S_CP_ISSUE;
                        end
                    end
                    CMD_STATUS: n_st = ST_DONE;
                    default: n_st = ST_RANGE;
                endcase
            end
            // Gather word bytes, or fetch the read byte, one read per pass
            S_RD_ISSUE: begin
                o_mem.raddr = w_rd_addr;
                n_state = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_mem.raddr = w_rd_addr;
                n_state = S_RD_TAKE;
            end
            S_RD_TAKE: begin
                if (r_cmd == CMD_READ) begin
                    n_rd = i_rdata; n_state = S_OUT;
                end else begin
                    n_word = r_word | (32'(i_rdata) << {r_cnt[1:0], 3'b000});
                    if (r_cnt + 3'd1 == w_nbytes) begin
                        n_cnt = '0; n_state = S_MODIFY;
                    end else begin
                        n_cnt = r_cnt + 3'd1; n_state = S_RD_ISSUE;
                    end
                end
            end
            S_MODIFY: begin
                n_word = w_new; n_state = S_WR_BACK;
            end
            // Scatter bytes back
            S_WR_BACK: begin
                o_mem.we = 1'b1; o_mem.waddr = w_base + ADDR_W'(r_cnt);
                o_mem.wdata = 8'(r_word >> {r_cnt[1:0], 3'b000});
                if (r_cnt + 3'd1 == w_nbytes) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            // Block move: one byte per read/write pass
            S_CP_ISSUE: begin
                if (r_left == '0) begin
                    case (r_phase)
                        PH_SAVE: begin
                            // Shift tail up, walking downward from the end
                            n_phase = PH_SHIFT; n_left = r_len - LEN_W'(r_dest);
                            n_ptr = r_len - 1'b1;
                        end
                        PH_SHIFT: begin
                            if (r_cmd == CMD_DELETE) begin
                                n_len = r_len - LEN_W'(r_blen); n_state = S_OUT;
                            end else begin
                                n_phase = PH_PLACE; n_ptr = '0;
                                n_left = LEN_W'(r_blen); n_state = S_BLK_WRITE;
                            end
                        end
                        default: begin
                            n_len = r_len + LEN_W'(r_blen); n_state = S_OUT;
                        end
                    endcase
                end else begin
                    o_mem.raddr = w_cp_addr;
                    n_state = S_CP_WAIT;
                end
            end
            S_CP_WAIT: begin
                o_mem.raddr = w_cp_addr;
                n_state = S_CP_WRITE;
            end
            S_CP_WRITE: begin
                n_left = r_left - 1'b1; n_state = S_CP_ISSUE;
                if (r_phase == PH_SAVE) begin
                    w_tmp_we = 1'b1; n_ptr = r_ptr + 1'b1;
                end else if (r_cmd == CMD_DELETE) begin
                    o_mem.we = 1'b1; o_mem.waddr = ADDR_W'(r_ptr);
                    o_mem.wdata = i_rdata; n_ptr = r_ptr + 1'b1;
                end else begin
                    o_mem.we = 1'b1; o_mem.waddr = ADDR_W'(r_ptr) + ADDR_W'(r_blen);
                    o_mem.wdata = i_rdata; n_ptr = r_ptr - 1'b1;
                end
            end
            S_BLK_WRITE: begin
                if (r_left == '0) begin
                    n_len = r_len + LEN_W'(r_blen); n_state = S_OUT;
                end else begin
                    o_mem.we = 1'b1; o_mem.waddr = ADDR_W'(r_dest) + ADDR_W'(r_ptr);
                    o_mem.wdata = r_tmp[4'(r_ptr)];
                    n_ptr = r_ptr + 1'b1; n_left = r_left - 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_read_data = r_rd;
    assign o_buffer_length = r_len;
    assign o_status = r_st;

    // Length never exceeds the buffer
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(BUF_BYTES)) else $error("length overflow");
    // A result is only ever offered after a check
    a_out_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) != S_IDLE) else $error("bad result path");
    // Length holds while waiting for the consumer
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_len)) else $error("length moved");
    // Skipped items leave the length unchanged
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && n_st != ST_DONE) |=> $stable(r_len))
        else $error("skip changed length");
endmodule

// ===== rtl/core/fuzz_buffer_mutation_engine_core.sv =====
// Each item is accepted, then checked; append, clear, status and skipped items then
// go to the result. A read fetches one byte; a word edit gathers its bytes, modifies
// the word and writes it back; delete pulls the tail down; duplicate saves the block,
// shifts the tail up and places the block. One item at a time: input reopens in the
// cycle after the result is taken. Synchronous active-low reset clears the length;
// buffer content is undefined until written. Uses fbme_pkg, fbme_seq, fbme_ram.
module fuzz_buffer_mutation_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic [14:0] i_position,
    input  logic [1:0]  i_size_select,
    input  logic [5:0]  i_amount,
    input  logic        i_subtract,
    input  logic        i_swap_before,
    input  logic        i_swap_after,
    input  logic [4:0]  i_table_index,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_block_length,
    input  logic [12:0] i_dest_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [12:0] o_buffer_length,
    output logic [1:0]  o_status
);
    import fbme_pkg::*;

    t_mem_req   w_mem;
    logic [7:0] w_rdata;

    fbme_seq u_seq (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd, .i_position, .i_size_select,
        .i_amount, .i_subtract, .i_swap_before, .i_swap_after, .i_table_index,
        .i_data_byte, .i_block_length, .i_dest_position,
        .o_mem(w_mem), .i_rdata(w_rdata),
        .o_valid, .i_stall, .o_read_data, .o_buffer_length, .o_status
    );

    fbme_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
        .i_clk, .i_we(w_mem.we), .i_waddr(w_mem.waddr), .i_wdata(w_mem.wdata),
        .i_raddr(w_mem.raddr), .o_rdata(w_rdata)
    );
endmodule
